/* sv/tcpp_pkg.sv */
// shared constants, widths and the cordic arctangent table for the tilted circle projector
// no dependencies; used by tcpp_cordic, tcpp_div and the top level
`default_nettype none

package tcpp_pkg;

  // angle path
  localparam int ANG_W        = 14;   // angle in 1/16 degree, one bit above the 13-bit fields
  localparam int CORDIC_STEPS = 16;
  localparam int X_W          = 33;   // q30 cordic vector with headroom
  localparam int Z_W          = 26;   // residual angle in q16 degrees
  localparam int TRIG_W       = 16;   // q14 sine and cosine in [-16384, 16384]
  localparam int TRIG_ONE     = 16384;

  localparam logic signed [X_W-1:0]   CORDIC_GAIN   = X_W'(652032874);
  localparam logic signed [ANG_W-1:0] FULL_TURN     = ANG_W'(5760);
  localparam logic signed [ANG_W-1:0] HALF_TURN     = ANG_W'(2880);
  localparam logic signed [ANG_W-1:0] QUARTER_TURN  = ANG_W'(1440);
  localparam logic signed [ANG_W-1:0] THREE_QUARTER = ANG_W'(4320);

  // projection path
  localparam int NUM_W    = 30;   // depth and numerators in 1/256 mm
  localparam int N_W      = 64;   // focal * numerator * pixel scale
  localparam int NM_W     = 48;   // numerator magnitude after the 65536 scale
  localparam int DIV_BITS = 15;   // quotient bits below the saturation bit
  localparam int PIX_W    = 16;

  // cycles from an accepted start to its done strobe
  localparam int CORDIC_LAT = CORDIC_STEPS + 2;
  localparam int MID_LAT    = 6;
  localparam int DIV_LAT    = DIV_BITS + 3;
  localparam int LAT        = CORDIC_LAT + MID_LAT + DIV_LAT;

  // register file
  localparam int ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_TILT_X = 3'd0,
    REG_TILT_Y = 3'd1,
    REG_RADIUS = 3'd2,
    REG_CX     = 3'd3,
    REG_CY     = 3'd4,
    REG_CZ     = 3'd5,
    REG_FOCAL  = 3'd6,
    REG_PPM    = 3'd7
  } reg_idx_t;

  // atan(2^-i) in q16 degrees
  function automatic logic signed [Z_W-1:0] atan_q16(input logic [3:0] idx);
    case (idx)
      4'd0:    atan_q16 = Z_W'(2949120);
      4'd1:    atan_q16 = Z_W'(1740967);
      4'd2:    atan_q16 = Z_W'(919879);
      4'd3:    atan_q16 = Z_W'(466945);
      4'd4:    atan_q16 = Z_W'(234379);
      4'd5:    atan_q16 = Z_W'(117304);
      4'd6:    atan_q16 = Z_W'(58666);
      4'd7:    atan_q16 = Z_W'(29335);
      4'd8:    atan_q16 = Z_W'(14668);
      4'd9:    atan_q16 = Z_W'(7334);
      4'd10:   atan_q16 = Z_W'(3667);
      4'd11:   atan_q16 = Z_W'(1833);
      4'd12:   atan_q16 = Z_W'(917);
      4'd13:   atan_q16 = Z_W'(458);
      4'd14:   atan_q16 = Z_W'(229);
      4'd15:   atan_q16 = Z_W'(115);
      default: atan_q16 = '0;
    endcase
  endfunction

endpackage

`default_nettype wire

/* sv/tcpp_cordic.sv */
// pipelined rotation-mode cordic: angle in 1/16 degree to q14 sine and cosine
// depends on tcpp_pkg; one angle per cycle
`default_nettype none

module tcpp_cordic (
  input  logic                               clk,
  input  logic signed [tcpp_pkg::ANG_W-1:0]  ang,
  output logic signed [tcpp_pkg::TRIG_W-1:0] sin_q14,
  output logic signed [tcpp_pkg::TRIG_W-1:0] cos_q14
);

  logic signed [tcpp_pkg::ANG_W-1:0] a_mod;
  logic signed [tcpp_pkg::ANG_W-1:0] a_fold;
  logic                              fold_neg;
  logic signed [tcpp_pkg::Z_W-1:0]   z0;

  logic signed [tcpp_pkg::X_W-1:0] xs [0:tcpp_pkg::CORDIC_STEPS];
  logic signed [tcpp_pkg::X_W-1:0] ys [0:tcpp_pkg::CORDIC_STEPS];
  logic signed [tcpp_pkg::Z_W-1:0] zs [0:tcpp_pkg::CORDIC_STEPS];
  logic                            negs [0:tcpp_pkg::CORDIC_STEPS];

  function automatic logic signed [tcpp_pkg::TRIG_W-1:0] to_q14(
    input logic signed [tcpp_pkg::X_W-1:0] v
  );
    logic signed [tcpp_pkg::X_W:0]    s;
    logic signed [tcpp_pkg::X_W-16:0] r;
    s = (tcpp_pkg::X_W+1)'(v) + 32768;
    r = (tcpp_pkg::X_W-15)'(s >>> 16);
    if (r > tcpp_pkg::TRIG_ONE) begin
      r = (tcpp_pkg::X_W-15)'(tcpp_pkg::TRIG_ONE);
    end else if (r < -tcpp_pkg::TRIG_ONE) begin
      r = -(tcpp_pkg::X_W-15)'(tcpp_pkg::TRIG_ONE);
    end
    to_q14 = tcpp_pkg::TRIG_W'(r);
  endfunction

  // reduce to one turn (exact for angles of -5760 and up), then fold into [-90, 90] degrees
  always_comb begin
    a_mod = ang;
    if (ang < 0) begin
      a_mod = ang + tcpp_pkg::FULL_TURN;
    end else if (ang >= tcpp_pkg::FULL_TURN) begin
      a_mod = ang - tcpp_pkg::FULL_TURN;
    end
    a_fold   = a_mod;
    fold_neg = 1'b0;
    if (a_mod > tcpp_pkg::QUARTER_TURN && a_mod <= tcpp_pkg::THREE_QUARTER) begin
      a_fold   = a_mod - tcpp_pkg::HALF_TURN;
      fold_neg = 1'b1;
    end else if (a_mod > tcpp_pkg::THREE_QUARTER) begin
      a_fold = a_mod - tcpp_pkg::FULL_TURN;
    end
    z0 = tcpp_pkg::Z_W'(a_fold) <<< 12;
  end

  always_ff @(posedge clk) begin
    xs[0]   <= tcpp_pkg::CORDIC_GAIN;
    ys[0]   <= '0;
    zs[0]   <= z0;
    negs[0] <= fold_neg;
    for (int i = 0; i < tcpp_pkg::CORDIC_STEPS; i++) begin
      if (zs[i] >= 0) begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        zs[i+1] <= zs[i] - tcpp_pkg::atan_q16(4'(i));
      end else begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        zs[i+1] <= zs[i] + tcpp_pkg::atan_q16(4'(i));
      end
      negs[i+1] <= negs[i];
    end
    if (negs[tcpp_pkg::CORDIC_STEPS]) begin
      sin_q14 <= -to_q14(ys[tcpp_pkg::CORDIC_STEPS]);
      cos_q14 <= -to_q14(xs[tcpp_pkg::CORDIC_STEPS]);
    end else begin
      sin_q14 <= to_q14(ys[tcpp_pkg::CORDIC_STEPS]);
      cos_q14 <= to_q14(xs[tcpp_pkg::CORDIC_STEPS]);
    end
  end

endmodule

`default_nettype wire

/* sv/tcpp_div.sv */
// pipelined restoring divider: saturated 16-bit quotient of n / (depth * 65536)
// depends on tcpp_pkg; one pair per cycle
`default_nettype none

module tcpp_div (
  input  logic                              clk,
  input  logic signed [tcpp_pkg::N_W-1:0]   n,
  input  logic signed [tcpp_pkg::NUM_W-1:0] depth,
  output logic signed [tcpp_pkg::PIX_W-1:0] pixel,
  output logic                              zero
);

  typedef struct packed {
    logic qneg;   // quotient sign
    logic npos;
    logic nneg;
    logic dz;     // zero depth
    logic ovf;    // magnitude at or above 32768
  } div_flags_t;

  logic [tcpp_pkg::N_W-1:0]   nmag;
  logic [tcpp_pkg::NUM_W-1:0] dmag;

  logic [tcpp_pkg::NM_W-1:0]  nm_a;
  logic [tcpp_pkg::NUM_W-1:0] dm_a;
  div_flags_t                 fl_a;
  div_flags_t                 fl_b;

  logic [tcpp_pkg::NM_W-1:0]     rem  [0:tcpp_pkg::DIV_BITS];
  logic [tcpp_pkg::NUM_W-1:0]    dms  [0:tcpp_pkg::DIV_BITS];
  logic [tcpp_pkg::DIV_BITS-1:0] qs   [0:tcpp_pkg::DIV_BITS];
  div_flags_t                    fls  [0:tcpp_pkg::DIV_BITS];
  logic [tcpp_pkg::NM_W-1:0]     trial [0:tcpp_pkg::DIV_BITS-1];

  assign nmag = n[tcpp_pkg::N_W-1] ? tcpp_pkg::N_W'(-n) : tcpp_pkg::N_W'(n);
  assign dmag = depth[tcpp_pkg::NUM_W-1] ? tcpp_pkg::NUM_W'(-depth) : tcpp_pkg::NUM_W'(depth);

  always_comb begin
    for (int i = 0; i < tcpp_pkg::DIV_BITS; i++) begin
      trial[i] = tcpp_pkg::NM_W'(dms[i]) << (tcpp_pkg::DIV_BITS - 1 - i);
    end
  end

  // saturation check folded into the flags
  always_comb begin
    fl_b     = fl_a;
    fl_b.ovf = nm_a >= (tcpp_pkg::NM_W'(dm_a) << tcpp_pkg::DIV_BITS);
  end

  always_ff @(posedge clk) begin
    // magnitudes and signs
    nm_a      <= nmag[tcpp_pkg::N_W-1:16];
    dm_a      <= dmag;
    fl_a.qneg <= n[tcpp_pkg::N_W-1] ^ depth[tcpp_pkg::NUM_W-1];
    fl_a.npos <= (n > 0);
    fl_a.nneg <= n[tcpp_pkg::N_W-1];
    fl_a.dz   <= (depth == '0);
    fl_a.ovf  <= 1'b0;

    // saturation check
    rem[0] <= nm_a;
    dms[0] <= dm_a;
    qs[0]  <= '0;
    fls[0] <= fl_b;

    // one quotient bit per stage, msb first
    for (int i = 0; i < tcpp_pkg::DIV_BITS; i++) begin
      if (rem[i] >= trial[i]) begin
        rem[i+1] <= rem[i] - trial[i];
        qs[i+1]  <= {qs[i][tcpp_pkg::DIV_BITS-2:0], 1'b1};
      end else begin
        rem[i+1] <= rem[i];
        qs[i+1]  <= {qs[i][tcpp_pkg::DIV_BITS-2:0], 1'b0};
      end
      dms[i+1] <= dms[i];
      fls[i+1] <= fls[i];
    end

    // sign, saturation and zero depth
    zero <= fls[tcpp_pkg::DIV_BITS].dz;
    if (fls[tcpp_pkg::DIV_BITS].dz) begin
      if (fls[tcpp_pkg::DIV_BITS].npos) begin
        pixel <= {1'b0, {(tcpp_pkg::PIX_W-1){1'b1}}};
      end else if (fls[tcpp_pkg::DIV_BITS].nneg) begin
        pixel <= {1'b1, {(tcpp_pkg::PIX_W-1){1'b0}}};
      end else begin
        pixel <= '0;
      end
    end else if (fls[tcpp_pkg::DIV_BITS].ovf) begin
      if (fls[tcpp_pkg::DIV_BITS].qneg) begin
        pixel <= {1'b1, {(tcpp_pkg::PIX_W-1){1'b0}}};
      end else begin
        pixel <= {1'b0, {(tcpp_pkg::PIX_W-1){1'b1}}};
      end
    end else if (fls[tcpp_pkg::DIV_BITS].qneg) begin
      pixel <= -tcpp_pkg::PIX_W'({1'b0, qs[tcpp_pkg::DIV_BITS]});
    end else begin
      pixel <= tcpp_pkg::PIX_W'({1'b0, qs[tcpp_pkg::DIV_BITS]});
    end
  end

endmodule

`default_nettype wire

/* sv/tilted_circle_point_projection_top.sv */
// top level of the tilted circle point projector: register file, trig, geometry and projection
// depends on tcpp_pkg, tcpp_cordic and tcpp_div
`default_nettype none

// one angle alpha enters per cycle (busy is always low) and its pixel_x, pixel_y and
// zero_depth leave the end of the pipeline for exactly one cycle, marked by done; the
// result cannot be held off, so the receiver must take every transfer as it comes. the
// pipeline is the 18-stage cordic, six multiply stages for the tilted geometry and the
// numerator products, and an 18-stage restoring divider whose inner stages each make one
// quotient bit. tilt sines and cosines run through their own cordic lanes beside alpha, so
// a register write is seen by the very next start; registers must only change while no
// transfer is in flight. coordinates truncate toward zero and saturate to 16 bits; at
// zero depth they take full scale by numerator sign, 0 if it is 0, and zero_depth is set.

module tilted_circle_point_projection_top (
  input  logic                               clk,
  input  logic                               rst,
  // command side
  input  logic                               start,
  output logic                               busy,
  input  logic [12:0]                        alpha,
  // result side
  output logic                               done,
  output logic signed [tcpp_pkg::PIX_W-1:0]  pixel_x,
  output logic signed [tcpp_pkg::PIX_W-1:0]  pixel_y,
  output logic                               zero_depth,
  // register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tcpp_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  // register file, raw bits
  logic [12:0] tilt_x;
  logic [12:0] tilt_y;
  logic [23:0] radius;
  logic [23:0] cx;
  logic [23:0] cy;
  logic [23:0] cz;
  logic [19:0] focal;
  logic [15:0] ppm;

  tcpp_pkg::reg_idx_t reg_idx;
  logic               wr_en;

  // valid bits, one per pipeline register stage
  logic [tcpp_pkg::LAT-1:0] vld;

  // trig outputs
  logic signed [tcpp_pkg::TRIG_W-1:0] s_a, c_a, s_x, c_x, s_y, c_y;

  // geometry stage 1: trig products
  logic signed [31:0] p_yx, p_ys, p_ya, p_xa_c, p_xa_s;
  logic signed [tcpp_pkg::TRIG_W-1:0] t1, t2, ca_d;
  logic signed [31:0] kx1, cxsa, sxsa;

  // geometry stage 2: q28 coefficients, channel 0 depth, 1 x, 2 y
  logic signed [31:0] p_t1, p_t2;
  logic signed [31:0] k [0:2];

  // geometry stage 3: coefficient times radius, split into two 12-bit halves
  logic signed [44:0] plo_next [0:2];
  logic signed [44:0] phi_next [0:2];
  logic signed [44:0] plo [0:2];
  logic signed [44:0] phi [0:2];

  // geometry stage 4: depth and numerators
  logic signed [56:0]                full [0:2];
  logic signed [tcpp_pkg::NUM_W-1:0] ctr  [0:2];
  logic signed [tcpp_pkg::NUM_W-1:0] val  [0:2];

  // numerator products, fp split into two 18-bit halves
  logic [35:0]                       fp;
  logic signed [48:0]                nlo_next [1:2];
  logic signed [48:0]                nhi_next [1:2];
  logic signed [48:0]                nlo [1:2];
  logic signed [48:0]                nhi [1:2];
  logic signed [tcpp_pkg::NUM_W-1:0] depth_d1, depth_d2;
  logic signed [tcpp_pkg::N_W-1:0]   nprod [1:2];

  logic zero_y;

  // the pipeline never stalls
  assign busy   = 1'b0;
  assign pready = 1'b1;

  // register port
  assign reg_idx = tcpp_pkg::reg_idx_t'(paddr[tcpp_pkg::ADDR_W-1:2]);
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tilt_x <= '0;
      tilt_y <= '0;
      radius <= '0;
      cx     <= '0;
      cy     <= '0;
      cz     <= 24'd256000;
      focal  <= 20'd2048;
      ppm    <= 16'd256;
    end else if (wr_en) begin
      case (reg_idx)
        tcpp_pkg::REG_TILT_X: tilt_x <= pwdata[12:0];
        tcpp_pkg::REG_TILT_Y: tilt_y <= pwdata[12:0];
        tcpp_pkg::REG_RADIUS: radius <= pwdata[23:0];
        tcpp_pkg::REG_CX:     cx     <= pwdata[23:0];
        tcpp_pkg::REG_CY:     cy     <= pwdata[23:0];
        tcpp_pkg::REG_CZ:     cz     <= pwdata[23:0];
        tcpp_pkg::REG_FOCAL:  focal  <= pwdata[19:0];
        tcpp_pkg::REG_PPM:    ppm    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tcpp_pkg::REG_TILT_X: prdata = 32'(tilt_x);
      tcpp_pkg::REG_TILT_Y: prdata = 32'(tilt_y);
      tcpp_pkg::REG_RADIUS: prdata = 32'(radius);
      tcpp_pkg::REG_CX:     prdata = 32'(cx);
      tcpp_pkg::REG_CY:     prdata = 32'(cy);
      tcpp_pkg::REG_CZ:     prdata = 32'(cz);
      tcpp_pkg::REG_FOCAL:  prdata = 32'(focal);
      tcpp_pkg::REG_PPM:    prdata = 32'(ppm);
      default:              prdata = '0;
    endcase
  end

  // valid travels beside the data, a start transfer enters every cycle it is asserted
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[tcpp_pkg::LAT-2:0], start};
    end
  end

  assign done = vld[tcpp_pkg::LAT-1];

  // three cordic lanes, tilt lanes follow the registers cycle by cycle
  tcpp_cordic u_cordic_a (
    .clk     (clk),
    .ang     ($signed({1'b0, alpha})),
    .sin_q14 (s_a),
    .cos_q14 (c_a)
  );

  tcpp_cordic u_cordic_x (
    .clk     (clk),
    .ang     ($signed({tilt_x[12], tilt_x})),
    .sin_q14 (s_x),
    .cos_q14 (c_x)
  );

  tcpp_cordic u_cordic_y (
    .clk     (clk),
    .ang     ($signed({tilt_y[12], tilt_y})),
    .sin_q14 (s_y),
    .cos_q14 (c_y)
  );

  // stage 1: q14 trig products
  assign p_yx   = s_y * c_x;
  assign p_ys   = s_y * s_x;
  assign p_ya   = c_y * c_a;
  assign p_xa_c = c_x * s_a;
  assign p_xa_s = s_x * s_a;

  always_ff @(posedge clk) begin
    t1   <= tcpp_pkg::TRIG_W'(p_yx >>> 14);
    t2   <= tcpp_pkg::TRIG_W'(p_ys >>> 14);
    ca_d <= c_a;
    kx1  <= p_ya;
    cxsa <= p_xa_c;
    sxsa <= p_xa_s;
  end

  // stage 2: bracket coefficients in q28
  assign p_t1 = t1 * ca_d;
  assign p_t2 = t2 * ca_d;

  always_ff @(posedge clk) begin
    k[0] <= sxsa - p_t1;
    k[1] <= kx1;
    k[2] <= p_t2 + cxsa;
  end

  // stage 3: times radius in two partial products
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      plo_next[c] = k[c] * $signed({1'b0, radius[11:0]});
      phi_next[c] = k[c] * $signed({1'b0, radius[23:12]});
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      plo[c] <= plo_next[c];
      phi[c] <= phi_next[c];
    end
  end

  // stage 4: combine, floor shift by 28, add the centre
  assign ctr[0] = tcpp_pkg::NUM_W'($signed(cz));
  assign ctr[1] = tcpp_pkg::NUM_W'($signed(cx));
  assign ctr[2] = tcpp_pkg::NUM_W'($signed(cy));

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      full[c] = (57'(phi[c]) <<< 12) + 57'(plo[c]);
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      val[c] <= tcpp_pkg::NUM_W'(full[c] >>> 28) + ctr[c];
    end
  end

  // focal times ppm; the user, not the block, keeps it steady while transfers are in flight
  always_ff @(posedge clk) begin
    fp <= focal * ppm;
  end

  // stage 5: numerator times fp in two partial products
  always_comb begin
    for (int c = 1; c < 3; c++) begin
      nlo_next[c] = val[c] * $signed({1'b0, fp[17:0]});
      nhi_next[c] = val[c] * $signed({1'b0, fp[35:18]});
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 1; c < 3; c++) begin
      nlo[c] <= nlo_next[c];
      nhi[c] <= nhi_next[c];
    end
    depth_d1 <= val[0];
  end

  // stage 6: full 64-bit numerator product
  always_ff @(posedge clk) begin
    for (int c = 1; c < 3; c++) begin
      nprod[c] <= tcpp_pkg::N_W'((68'(nhi[c]) <<< 18) + 68'(nlo[c]));
    end
    depth_d2 <= depth_d1;
  end

  // divide, saturate and flag zero depth
  tcpp_div u_div_x (
    .clk   (clk),
    .n     (nprod[1]),
    .depth (depth_d2),
    .pixel (pixel_x),
    .zero  (zero_depth)
  );

  tcpp_div u_div_y (
    .clk   (clk),
    .n     (nprod[2]),
    .depth (depth_d2),
    .pixel (pixel_y),
    .zero  (zero_y)
  );

  // both dividers see the same depth; the y copy of the flag only matches the x one
  logic unused_zero;
  assign unused_zero = zero_y;

endmodule

`default_nettype wire

/* bench/tcpp_projection_checker.sv */
// checker for the tilted circle projector: mirrors the register file, predicts each pixel
// transfer and compares it with the done strobe; depends on tcpp_pkg
module tcpp_projection_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              busy,
  input  logic [12:0]                       alpha,
  input  logic                              done,
  input  logic signed [tcpp_pkg::PIX_W-1:0] pixel_x,
  input  logic signed [tcpp_pkg::PIX_W-1:0] pixel_y,
  input  logic                              zero_depth,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic                              pready,
  input  logic [tcpp_pkg::ADDR_W-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output int                                errors,
  output int                                pending
);

  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic               zd;
  } pixel_t;

  localparam longint ARCTAN [16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                                     58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                     229, 115};

  logic signed [12:0] tilt_x, tilt_y;
  logic        [23:0] radius;
  logic signed [23:0] cen_x, cen_y, cen_z;
  logic        [19:0] focal;
  logic        [15:0] ppm;

  pixel_t pixel_queue[$];

  function automatic longint q14_round(input longint v);
    longint r;
    r = (v + 32768) >>> 16;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r;
  endfunction

  // cordic sine and cosine in q14, angle in 1/16 degree
  function automatic void sin_cos(input longint ang, output longint s, output longint c);
    longint a, x, y, z, nx;
    bit     flip;
    a = ang % 5760;
    flip = 0;
    if (a < 0) a += 5760;
    if (a > 1440 && a <= 4320) begin
      a -= 2880;
      flip = 1;
    end else if (a > 4320) begin
      a -= 5760;
    end
    x = 652032874;
    y = 0;
    z = a * 4096;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= ARCTAN[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += ARCTAN[i];
      end
      x = nx;
    end
    s = q14_round(y);
    c = q14_round(x);
    if (flip) begin
      s = -s;
      c = -c;
    end
  endfunction

  function automatic longint to_pixel(input longint num, input longint depth);
    longint n, q;
    n = longint'(focal) * num * longint'(ppm);
    if (depth == 0) return (n > 0) ? 32767 : (n < 0) ? -32768 : 0;
    q = n / (depth * 65536);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q;
  endfunction

  function automatic pixel_t project_point(input logic [12:0] ang);
    longint sa, ca, sx, cx, sy, cy, kd, kx, ky, depth, nx, ny, r;
    pixel_t p;
    sin_cos(longint'(ang), sa, ca);
    sin_cos(longint'(tilt_x), sx, cx);
    sin_cos(longint'(tilt_y), sy, cy);
    r  = longint'(radius);
    kd = -((sy * cx) >>> 14) * ca + sx * sa;
    kx = cy * ca;
    ky = ((sy * sx) >>> 14) * ca + cx * sa;
    depth = ((kd * r) >>> 28) + longint'(cen_z);
    nx    = ((kx * r) >>> 28) + longint'(cen_x);
    ny    = ((ky * r) >>> 28) + longint'(cen_y);
    p.px = 16'(to_pixel(nx, depth));
    p.py = 16'(to_pixel(ny, depth));
    p.zd = (depth == 0);
    return p;
  endfunction

  always @(posedge clk) begin
    pixel_t want;
    if (rst) begin
      tilt_x  <= '0;
      tilt_y  <= '0;
      radius  <= '0;
      cen_x   <= '0;
      cen_y   <= '0;
      cen_z   <= 24'd256000;
      focal   <= 20'd2048;
      ppm     <= 16'd256;
      errors  <= 0;
      pixel_queue.delete();
      pending <= 0;
    end else begin
      if (done) begin
        if (pixel_queue.size() == 0) begin
          $display("%0t: unexpected transfer px=%0d py=%0d zd=%0b",
                   $time, pixel_x, pixel_y, zero_depth);
          errors <= errors + 1;
        end else begin
          want = pixel_queue.pop_front();
          if (want.px !== pixel_x || want.py !== pixel_y || want.zd !== zero_depth) begin
            $display("%0t: expected px=%0d py=%0d zd=%0b, got px=%0d py=%0d zd=%0b",
                     $time, want.px, want.py, want.zd, pixel_x, pixel_y, zero_depth);
            errors <= errors + 1;
          end
        end
      end
      if (start && !busy) pixel_queue.insert(pixel_queue.size(), project_point(alpha));
      pending <= pixel_queue.size();
      if (psel && penable && pwrite && pready) begin
        case (tcpp_pkg::reg_idx_t'(paddr[4:2]))
          tcpp_pkg::REG_TILT_X: tilt_x <= pwdata[12:0];
          tcpp_pkg::REG_TILT_Y: tilt_y <= pwdata[12:0];
          tcpp_pkg::REG_RADIUS: radius <= pwdata[23:0];
          tcpp_pkg::REG_CX:     cen_x  <= pwdata[23:0];
          tcpp_pkg::REG_CY:     cen_y  <= pwdata[23:0];
          tcpp_pkg::REG_CZ:     cen_z  <= pwdata[23:0];
          tcpp_pkg::REG_FOCAL:  focal  <= pwdata[19:0];
          tcpp_pkg::REG_PPM:    ppm    <= pwdata[15:0];
          default: ;
        endcase
      end
    end
  end

endmodule

/* bench/tilted_circle_point_projection_top_tb.sv */
// testbench top for the tilted circle projector: clock, reset, register writes and angle stimulus
// depends on tcpp_pkg, tilted_circle_point_projection_top and tcpp_projection_checker
module tilted_circle_point_projection_top_tb;

  localparam int CYCLE_LIMIT = 400000;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        start = 1'b0;
  logic [12:0]                 alpha = '0;
  logic                        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [tcpp_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]                 pwdata = '0;
  logic                        busy, done, zero_depth, pready;
  logic signed [15:0]          pixel_x, pixel_y;
  logic [31:0]                 prdata;
  int                          errors, pending;
  int                          cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  tilted_circle_point_projection_top DUT (
    .clk, .rst, .start, .busy, .alpha, .done, .pixel_x, .pixel_y, .zero_depth,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  tcpp_projection_checker checker_i (
    .clk, .rst, .start, .busy, .alpha, .done, .pixel_x, .pixel_y, .zero_depth,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .errors, .pending
  );

  // hard stop if the run hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // setup cycle then access cycle; the write lands at the end of the access cycle
  task automatic reg_write(input tcpp_pkg::reg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= tcpp_pkg::ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_regs(input int tx, input int ty, input int r, input int cx,
                           input int cy, input int cz, input int f, input int p);
    reg_write(tcpp_pkg::REG_TILT_X, tx);
    reg_write(tcpp_pkg::REG_TILT_Y, ty);
    reg_write(tcpp_pkg::REG_RADIUS, r);
    reg_write(tcpp_pkg::REG_CX, cx);
    reg_write(tcpp_pkg::REG_CY, cy);
    reg_write(tcpp_pkg::REG_CZ, cz);
    reg_write(tcpp_pkg::REG_FOCAL, f);
    reg_write(tcpp_pkg::REG_PPM, p);
  endtask

  // sample status at the falling edge so reads never race the rising-edge updates,
  // then return on a rising edge so the next drive lines up with the clock
  task automatic wait_drained();
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // hold start until a transfer is taken, then maybe leave a gap
  task automatic send_angle(input logic [12:0] a, input int gap);
    bit taken;
    start <= 1'b1;
    alpha <= a;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // end a burst: drop start, let every transfer come back
  task automatic finish_burst();
    start <= 1'b0;
    @(posedge clk);
    wait_drained();
  endtask

  function automatic int signed_rand(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  initial begin
    logic [12:0] edge_angles [12] = '{13'd0, 13'd1, 13'd1439, 13'd1440, 13'd1441, 13'd2880,
                                       13'd4320, 13'd4321, 13'd5759, 13'd5760, 13'd8191,
                                       13'd4096};
    int burst;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values, angle fold boundaries and out of range patterns
    foreach (edge_angles[i]) send_angle(edge_angles[i], 0);
    finish_burst();

    // half-turn tilts with a large circle
    load_regs(-2880, 2880, 200000, 1000, -2000, 1000000, 4096, 512);
    send_angle(13'd0, 0);
    send_angle(13'd1440, 1);
    send_angle(13'd2880, 0);
    finish_burst();

    // zero depth: coordinates go to full scale by numerator sign, or zero
    load_regs(0, 0, 0, 5000, -5000, 0, 2048, 256);
    send_angle(13'd100, 0);
    finish_burst();
    reg_write(tcpp_pkg::REG_CX, 0);
    send_angle(13'd200, 0);
    finish_burst();

    // out of range tilt patterns, negative depth, saturation
    load_regs(4095, -4096, 16777215, 8388607, -8388608, -300000, 1048575, 65535);
    send_angle(13'd777, 0);
    send_angle(13'd3000, 0);
    finish_burst();
    load_regs(0, 0, 100, 8388607, -8388608, 1, 1048575, 65535);
    send_angle(13'd0, 0);
    finish_burst();

    // zero focal length and zero pixel scale
    load_regs(160, -160, 5000, 3000, 3000, 50000, 0, 256);
    send_angle(13'd500, 0);
    finish_burst();
    reg_write(tcpp_pkg::REG_FOCAL, 2048);
    reg_write(tcpp_pkg::REG_PPM, 0);
    send_angle(13'd500, 0);
    finish_burst();

    // random bursts, each under a fresh register setting
    for (burst = 0; burst < 13; burst++) begin
      if ($urandom_range(0, 3) == 0)
        load_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom);
      else
        load_regs(signed_rand(2880), signed_rand(2880), $urandom_range(0, 400000),
                  signed_rand(300000), signed_rand(300000),
                  $urandom_range(100000, 4000000), $urandom_range(256, 40000),
                  $urandom_range(1, 65535));
      for (int k = 0; k < 110; k++) begin
        // one pause until the pipeline is empty in the middle of the run
        if (burst == 6 && k == 55) finish_burst();
        send_angle(13'($urandom), (burst % 4 == 3) ? 0 : pick_gap());
      end
      finish_burst();
    end

    repeat (tcpp_pkg::LAT + 20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* files.f */
sv/tcpp_pkg.sv
sv/tcpp_cordic.sv
sv/tcpp_div.sv
sv/tilted_circle_point_projection_top.sv
bench/tcpp_projection_checker.sv
bench/tilted_circle_point_projection_top_tb.sv
